### sv/imuc_pkg.sv
// ----------------------------------------------------------------------------
// imuc_pkg
// Shared types and constants of the IMU offset calibration block: the input
// and result words, register indexes and the scaling constants.
// ----------------------------------------------------------------------------
package imuc_pkg;

    // One raw six-axis sample with its flags.
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic               sample_ok;
        logic               run_end;
    } in_word_t;

    // One calibration result.
    typedef struct packed {
        logic signed [11:0] accel_off_x;
        logic signed [11:0] accel_off_y;
        logic signed [11:0] accel_off_z;
        logic signed [11:0] gyro_off_x;
        logic signed [11:0] gyro_off_y;
        logic signed [11:0] gyro_off_z;
        logic               calib_status;
    } out_word_t;

    // Register indexes on the configuration port.
    localparam logic REG_ACCEL_RANGE = 1'b0;
    localparam logic REG_GYRO_RANGE  = 1'b1;

    localparam logic [1:0] RANGE_SEL_RESET = 2'd2;

    // Status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    localparam int NUM_AXES  = 6;
    localparam int AXIS_W    = 3;
    localparam int LSB_W     = 15;
    localparam int MUL_W     = 12;
    localparam int PROD_W    = 16 + MUL_W;
    localparam int OFF_W     = 12;

    localparam logic [LSB_W-1:0] ACC_LSB_FULL = 15'd16384;
    localparam logic [MUL_W-1:0] ACC_MUL      = 12'd2000;
    localparam logic [MUL_W-1:0] GYR_MUL      = 12'd32;
    localparam logic [OFF_W-1:0] OFF_MAX      = 12'd2047;
    localparam logic [OFF_W-1:0] OFF_MIN      = 12'h800;

    // Axis holding gravity, whose target is one g.
    localparam logic [AXIS_W-1:0] AXIS_ACCEL_Z = 3'd2;
    localparam logic [AXIS_W-1:0] AXIS_LAST    = 3'd5;
    localparam logic [AXIS_W-1:0] AXIS_GYRO_0  = 3'd3;

    // Integer LSB per dps for each gyro full scale.
    function automatic logic [LSB_W-1:0] gyro_lsb(input logic [1:0] sel);
        logic [LSB_W-1:0] v;
        case (sel)
            2'd0:    v = 15'd131;
            2'd1:    v = 15'd65;
            2'd2:    v = 15'd32;
            default: v = 15'd16;
        endcase
        return v;
    endfunction

    function automatic logic [LSB_W-1:0] accel_lsb(input logic [1:0] sel);
        return ACC_LSB_FULL >> sel;
    endfunction

endpackage

### sv/imuc_front.sv
// ----------------------------------------------------------------------------
// imuc_front
// Accepts sample words, accumulates valid samples into six sums and a count,
// and hands a finished run to the job queue on the last word.
// ----------------------------------------------------------------------------
module imuc_front
    import imuc_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int SUM_W      = COUNT_BITS + 16,
    parameter int JOB_W      = NUM_AXES * SUM_W + COUNT_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  in_word_t         sample_data,
    input  logic             queue_full,
    output logic             push,
    output logic [JOB_W-1:0] push_job
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic signed [SUM_W-1:0]  sum_reg  [NUM_AXES];
    logic signed [SUM_W-1:0]  sum_next [NUM_AXES];
    logic [COUNT_BITS-1:0]    count_reg;
    logic [COUNT_BITS-1:0]    count_next;
    logic [15:0]              axis_in  [NUM_AXES];
    logic                     accept;
    logic                     take;

    assign axis_in[0] = sample_data.accel_x;
    assign axis_in[1] = sample_data.accel_y;
    assign axis_in[2] = sample_data.accel_z;
    assign axis_in[3] = sample_data.gyro_x;
    assign axis_in[4] = sample_data.gyro_y;
    assign axis_in[5] = sample_data.gyro_z;

    assign sample_ready = !queue_full;
    assign accept       = sample_valid && sample_ready;
    // A saturated count freezes the run until its last word.
    assign take         = sample_data.sample_ok && (count_reg != COUNT_MAX);

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            sum_next[i] = take ? sum_reg[i] + {{(SUM_W-16){axis_in[i][15]}}, axis_in[i]}
                               : sum_reg[i];
        end
        count_next = take ? count_reg + 1'b1 : count_reg;
    end

    assign push = accept && sample_data.run_end;

    always_comb
    begin
        push_job = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            push_job[i*SUM_W +: SUM_W] = sum_next[i];
        end
        push_job[NUM_AXES*SUM_W +: COUNT_BITS] = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                sum_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else if (accept)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                sum_reg[i] <= sample_data.run_end ? '0 : sum_next[i];
            end
            count_reg <= sample_data.run_end ? '0 : count_next;
        end
    end

endmodule

### sv/imuc_queue.sv
// ----------------------------------------------------------------------------
// imuc_queue
// Two-entry queue of finished runs between the accumulator and the solver.
// ----------------------------------------------------------------------------
module imuc_queue
    import imuc_pkg::*;
#(
    parameter int JOB_W = 112
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [JOB_W-1:0] push_job,
    output logic             full,
    output logic             job_valid,
    output logic [JOB_W-1:0] job,
    input  logic             pop
);

    logic [JOB_W-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;

    assign full      = fill_reg[1];
    assign job_valid = (fill_reg != 2'd0);
    assign job       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

### sv/imuc_div.sv
// ----------------------------------------------------------------------------
// imuc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module imuc_div
    import imuc_pkg::*;
#(
    parameter int DVD_W = 32,
    parameter int DVS_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   trial;

    assign shifted  = {rem_reg, quo_reg[DVD_W-1]};
    assign trial    = shifted - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so its top bit drops out.
            if (!trial[DVS_W])
            begin
                rem_reg <= trial[DVS_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DVS_W-1:0];
                quo_reg <= {quo_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### sv/imuc_back.sv
// ----------------------------------------------------------------------------
// imuc_back
// Solver for one finished run: per axis it forms the mean, the raw offset and
// the scaled, rounded and clamped register value, then presents the result.
// ----------------------------------------------------------------------------
module imuc_back
    import imuc_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int SUM_W      = COUNT_BITS + 16,
    parameter int JOB_W      = NUM_AXES * SUM_W + COUNT_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  logic [JOB_W-1:0] job,
    output logic             pop,
    input  logic [1:0]       accel_range_sel,
    input  logic [1:0]       gyro_range_sel,
    output logic             result_valid,
    input  logic             result_ready,
    output out_word_t        result_data
);

    localparam int DVD_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int DVS_W = (COUNT_BITS > LSB_W) ? COUNT_BITS : LSB_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_MEAN  = 3'd2;
    localparam logic [2:0] ST_OFF   = 3'd3;
    localparam logic [2:0] ST_ROUND = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0]              state_reg;
    logic [AXIS_W-1:0]       axis_reg;
    logic                    neg_reg;
    logic [15:0]             mean_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [OFF_W-1:0]        res_reg [NUM_AXES];
    logic                    status_reg;
    logic                    out_valid_reg;
    out_word_t               out_reg;

    logic signed [SUM_W-1:0] sums [NUM_AXES];
    logic [COUNT_BITS-1:0]   count;
    logic signed [SUM_W-1:0] cur_sum;
    logic [SUM_W-1:0]        sum_mag;
    logic                    is_accel;
    logic [LSB_W-1:0]        lsb;
    logic [LSB_W-1:0]        acc_lsb;
    logic [15:0]             target;
    logic [15:0]             offset;
    logic [MUL_W-1:0]        mul;
    logic [PROD_W-1:0]       prod_mag;
    logic [OFF_W-1:0]        clamped;

    logic                    div_start;
    logic [DVD_W-1:0]        div_dividend;
    logic [DVS_W-1:0]        div_divisor;
    logic                    div_done;
    logic [DVD_W-1:0]        div_quotient;
    logic                    out_free;

    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            sums[i] = job[i*SUM_W +: SUM_W];
        end
        count = job[NUM_AXES*SUM_W +: COUNT_BITS];
    end

    assign cur_sum  = sums[axis_reg];
    assign sum_mag  = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : cur_sum;
    assign is_accel = (axis_reg < AXIS_GYRO_0);
    assign acc_lsb  = accel_lsb(accel_range_sel);
    assign lsb      = is_accel ? acc_lsb : gyro_lsb(gyro_range_sel);
    assign mul      = is_accel ? ACC_MUL : GYR_MUL;

    // Gravity axis aims at one g with the sign of its mean; zero counts as plus.
    always_comb
    begin
        target = '0;
        if (axis_reg == AXIS_ACCEL_Z)
        begin
            target = mean_reg[15] ? 16'd0 - {1'b0, acc_lsb} : {1'b0, acc_lsb};
        end
    end

    assign offset   = target - mean_reg;
    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(0) - prod_reg : prod_reg;

    // For the scaling, round half away from zero by adding half the divisor to the magnitude.
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DVD_W'(sum_mag);
        div_divisor  = DVS_W'(count);
        if (state_reg == ST_LOAD)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == ST_ROUND)
        begin
            div_start    = 1'b1;
            div_dividend = DVD_W'(prod_mag) + DVD_W'(lsb >> 1);
            div_divisor  = DVS_W'(lsb);
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            clamped = (div_quotient > DVD_W'(2048)) ? OFF_MIN
                                                    : OFF_W'(0) - div_quotient[OFF_W-1:0];
        end
        else
        begin
            clamped = (div_quotient > DVD_W'(OFF_MAX)) ? OFF_MAX : div_quotient[OFF_W-1:0];
        end
    end

    imuc_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_free     = !out_valid_reg || result_ready;
    assign pop          = (state_reg == ST_OUT) && out_free;
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                axis_reg   <= '0;
                status_reg <= (job_valid && (count == '0)) ? STATUS_EMPTY : STATUS_OK;
                if (job_valid && (count == '0))
                begin
                    for (int i = 0; i < NUM_AXES; i++)
                    begin
                        res_reg[i] <= '0;
                    end
                end
            end
            ST_LOAD:
            begin
                neg_reg <= cur_sum[SUM_W-1];
            end
            ST_MEAN:
            begin
                if (div_done)
                begin
                    mean_reg <= neg_reg ? 16'd0 - div_quotient[15:0] : div_quotient[15:0];
                end
            end
            ST_OFF:
            begin
                prod_reg <= {{(PROD_W-16){offset[15]}}, offset} * {{(PROD_W-MUL_W){1'b0}}, mul};
            end
            ST_ROUND:
            begin
                neg_reg <= prod_reg[PROD_W-1];
            end
            ST_SCALE:
            begin
                if (div_done)
                begin
                    res_reg[axis_reg] <= clamped;
                    axis_reg          <= axis_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_reg.accel_off_x  <= res_reg[0];
                    out_reg.accel_off_y  <= res_reg[1];
                    out_reg.accel_off_z  <= res_reg[2];
                    out_reg.gyro_off_x   <= res_reg[3];
                    out_reg.gyro_off_y   <= res_reg[4];
                    out_reg.gyro_off_z   <= res_reg[5];
                    out_reg.calib_status <= status_reg;
                end
            end
            default:
            begin
                axis_reg <= '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A new word loads as the old one leaves, so valid stays up.
            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        state_reg <= (count == '0) ? ST_OUT : ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= ST_MEAN;
                end
                ST_MEAN:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_OFF;
                    end
                end
                ST_OFF:
                begin
                    state_reg <= ST_ROUND;
                end
                ST_ROUND:
                begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE:
                begin
                    if (div_done)
                    begin
                        state_reg <= (axis_reg == AXIS_LAST) ? ST_OUT : ST_LOAD;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### sv/imu_offset_calibration.sv
// A run with no valid sample skips the solver and still gives its result word.
// Throughput: one sample word per cycle; the shared bit-serial divider, used twice per axis,
// sets the solve time. Input stalls while two finished runs are held: one being solved, one waiting.
// Reset: rst_n is asynchronous and active low; it clears the sums, the count, the queue, the
// output valid flag and sets both range selects to 2.
// ----------------------------------------------------------------------------
// imu_offset_calibration
// Six-axis IMU bias calibration by averaging: sums valid samples over a run
// and converts the per-axis means into clamped 12-bit offset register values.
// ----------------------------------------------------------------------------
module imu_offset_calibration
    import imuc_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    // Sample words in.
    input  logic        sample_valid,
    output logic        sample_ready,
    input  in_word_t    sample_data,

    // Result words out.
    output logic        result_valid,
    input  logic        result_ready,
    output out_word_t   result_data,

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The sums are kept wide enough that a saturated count of full-scale
    // samples never overflows them.
    localparam int SUM_W = COUNT_BITS + 16;
    localparam int JOB_W = NUM_AXES * SUM_W + COUNT_BITS;

    logic [1:0]       accel_range_reg;
    logic [1:0]       gyro_range_reg;
    logic             cfg_write;
    logic             queue_full;
    logic             push;
    logic [JOB_W-1:0] push_job;
    logic             job_valid;
    logic [JOB_W-1:0] job;
    logic             pop;

    // Register file. The port never waits, and registers sit four bytes
    // apart, so the index is address bit two.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_range_reg <= RANGE_SEL_RESET;
            gyro_range_reg  <= RANGE_SEL_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_ACCEL_RANGE)
            begin
                accel_range_reg <= pwdata[1:0];
            end
            else
            begin
                gyro_range_reg <= pwdata[1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_ACCEL_RANGE) ? {30'd0, accel_range_reg}
                                                  : {30'd0, gyro_range_reg};

    // Front end: accumulation at the full word rate while the queue has room.
    imuc_front #(
        .COUNT_BITS (COUNT_BITS),
        .SUM_W      (SUM_W),
        .JOB_W      (JOB_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .queue_full   (queue_full),
        .push         (push),
        .push_job     (push_job)
    );

    // Finished runs wait here so that sampling of the next run carries on
    // while the solver is busy or its output is stalled.
    imuc_queue #(
        .JOB_W (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .job_valid (job_valid),
        .job       (job),
        .pop       (pop)
    );

    // Back end: means, offsets and scaling, one axis after another. The
    // range selects are to be changed by the user only while the block is
    // idle; the block does not enforce this, and they are read directly.
    imuc_back #(
        .COUNT_BITS (COUNT_BITS),
        .SUM_W      (SUM_W),
        .JOB_W      (JOB_W)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (job_valid),
        .job             (job),
        .pop             (pop),
        .accel_range_sel (accel_range_reg),
        .gyro_range_sel  (gyro_range_reg),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .result_data     (result_data)
    );

endmodule

### sv/imuc_checker.sv
// ----------------------------------------------------------------------------
// imuc_checker
// Port-level checks of the IMU offset calibration block, bound to its top.
// ----------------------------------------------------------------------------
module imuc_checker
    import imuc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input out_word_t   result_data,
    input logic [31:0] prdata,
    input logic        pready
);

    // A stalled result word holds its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result word changed while stalled");

    // An empty run reports zero offsets.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.calib_status == STATUS_EMPTY) |->
            (result_data.accel_off_x == '0) && (result_data.accel_off_y == '0) &&
            (result_data.accel_off_z == '0) && (result_data.gyro_off_x == '0) &&
            (result_data.gyro_off_y == '0) && (result_data.gyro_off_z == '0))
        else $error("empty run with non-zero offsets");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // Only the two range-select bits read back.
    a_prdata: assert property (@(posedge clk) disable iff (!rst_n) prdata[31:2] == '0)
        else $error("unused read data bits set");

endmodule

bind imu_offset_calibration imuc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data),
    .prdata       (prdata),
    .pready       (pready)
);
